// File: design/facw_pkg.sv
// Shared types and constants for the fully associative FIFO write-back cache.
// No dependencies; imported by facw_cell and fully_assoc_cache_fifo_writeback.
package facw_pkg;

    localparam int DEF_TOTAL_WORDS = 256;
    localparam int DEF_ADDR_BITS   = 32;

    localparam int MODE_W = 4;
    localparam int CNT_W  = 32;
    localparam int BSZ_W  = 8;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_MIN   = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_MAX   = MODE_W'(8);

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // Lookup token walking the cell row.
    typedef struct packed {
        logic act;    // token present
        logic found;  // an earlier cell already matched
        logic wb;     // victim cell was valid and dirty
    } t_token;

    // Update controls broadcast to every cell.
    typedef struct packed {
        logic wr_en;     // fill the victim cell
        logic wr_dirty;  // dirty bit of the new entry
        logic is_write;  // current access is a write
    } t_bcast;

endpackage

// File: design/fully_assoc_cache_fifo_writeback.sv
// Fully associative write-back cache with FIFO replacement, cell-row lookup.
// Sequence: the access is latched, its token enters cell 0 through a register and
// walks the cell row; at its return ST_FIN loads the output register (o_m_axis_tvalid).
// One access at a time: a new one is accepted only in ST_IDLE; the
// lookup token walks the row one cell per clock, a stalled result holds the next access.
// Reset (i_rst_n low, synchronous) clears valid/dirty, FIFO pointer, counters; mode = 1.
module fully_assoc_cache_fifo_writeback #(
    parameter int TOTAL_WORDS = facw_pkg::DEF_TOTAL_WORDS,
    parameter int ADDR_BITS   = facw_pkg::DEF_ADDR_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config write channel: block_size_mode
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [facw_pkg::MODE_W-1:0]  i_cfg_data,
    // access input
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [31:0]                  i_s_axis_tdata,   // [31:0] address
    input  logic                         i_s_axis_tuser,   // [0] op
    // result output
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [31:0] words_read, [63:32] words_written, [95:64] read_hits,
    // [127:96] read_misses, [159:128] write_hits, [191:160] write_misses
    output logic [191:0]                 o_m_axis_tdata,
    output logic [1:0]                   o_m_axis_tuser    // [0] hit, [1] writeback
);
    import facw_pkg::*;

    // stored address width: input field is 32 bits, masked to ADDR_BITS
    localparam int AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int IW = $clog2(TOTAL_WORDS);
    localparam int CW = $clog2(TOTAL_WORDS + 1);
    localparam int NCNT = 6;

    // counter slots
    localparam int C_WRD   = 0;
    localparam int C_WWR   = 1;
    localparam int C_RHIT  = 2;
    localparam int C_RMISS = 3;
    localparam int C_WHIT  = 4;
    localparam int C_WMISS = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_state            r_state, n_state;
    logic [MODE_W-1:0] r_mode;

    // per-access context, latched at input transaction
    logic              r_op;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_mask;
    logic [CW-1:0]     r_count;
    logic [IW-1:0]     r_vic;
    logic [BSZ_W-1:0]  r_bsize;
    t_token            r_tok0;

    logic [IW-1:0]     r_ptr;
    logic [CNT_W-1:0]  r_cnt [NCNT];
    logic [CNT_W-1:0]  n_cnt [NCNT];

    // result waiting for the output register
    logic              r_hit;
    logic              r_wb;

    // output register
    logic              r_ovalid;
    logic [CNT_W-1:0]  r_ocnt [NCNT];
    logic              r_ohit;
    logic              r_owb;

    // ---------------------------------------------------------------
    // Cell row
    // ---------------------------------------------------------------
    t_token tok [TOTAL_WORDS+1];
    t_bcast bc;

    assign tok[0] = r_tok0;

    for (genvar g = 0; g < TOTAL_WORDS; g++) begin : g_cell
        facw_cell #(
            .TOTAL_WORDS (TOTAL_WORDS),
            .ADDR_W      (AW),
            .IDX         (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .i_bc    (bc),
            .i_vic   (r_vic),
            .i_addr  (r_addr),
            .i_mask  (r_mask),
            .i_count (r_count)
        );
    end

    // ---------------------------------------------------------------
    // Handshake and control
    // ---------------------------------------------------------------
    logic in_acc;
    logic tok_back;     // token left the last cell
    logic miss;
    logic out_free;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        in_acc   = i_s_axis_tvalid && o_s_axis_tready;
        tok_back = (r_state == ST_SCAN) && tok[TOTAL_WORDS].act;
        miss     = !tok[TOTAL_WORDS].found;
        out_free = !r_ovalid || i_m_axis_tready;
        bc.wr_en    = tok_back && miss;
        bc.wr_dirty = (r_op == OP_WRITE);
        bc.is_write = (r_op == OP_WRITE);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_acc)   n_state = ST_SCAN;
            ST_SCAN: if (tok_back) n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // mode decode for the incoming access: clamp to 1..8
    logic [MODE_W-1:0] mode_c;
    logic [2:0]        shift_c;
    logic [CW-1:0]     count_raw;
    logic [CW-1:0]     count_c;
    logic [IW-1:0]     vic_c;

    always_comb begin
        if (r_mode < MODE_MIN) begin
            mode_c = MODE_MIN;
        end else if (r_mode > MODE_MAX) begin
            mode_c = MODE_MAX;
        end else begin
            mode_c = r_mode;
        end
        shift_c   = 3'(mode_c - MODE_MIN);
        count_raw = CW'(TOTAL_WORDS) >> shift_c;
        count_c   = (count_raw == '0) ? CW'(1) : count_raw;
        // pointer past the entry count (mode change without reset) restarts at 0
        vic_c     = ({{(CW-IW){1'b0}}, r_ptr} >= count_c) ? '0 : r_ptr;
    end

    // next FIFO pointer after a fill
    logic [CW-1:0] vic_inc;
    logic [IW-1:0] ptr_next;

    always_comb begin
        vic_inc  = {{(CW-IW){1'b0}}, r_vic} + CW'(1);
        ptr_next = (vic_inc >= r_count) ? '0 : IW'(vic_inc);
    end

    // counter updates at token return
    always_comb begin
        logic [CNT_W-1:0] bsz;
        bsz = {{(CNT_W-BSZ_W){1'b0}}, r_bsize};
        for (int k = 0; k < NCNT; k++) begin
            n_cnt[k] = r_cnt[k];
        end
        if (tok_back) begin
            if (!miss) begin
                if (r_op == OP_WRITE) begin
                    n_cnt[C_WHIT] = sat_add(r_cnt[C_WHIT], CNT_W'(1));
                end else begin
                    n_cnt[C_RHIT] = sat_add(r_cnt[C_RHIT], CNT_W'(1));
                end
            end else begin
                n_cnt[C_WRD] = sat_add(r_cnt[C_WRD], bsz);
                if (tok[TOTAL_WORDS].wb) begin
                    n_cnt[C_WWR] = sat_add(r_cnt[C_WWR], bsz);
                end
                if (r_op == OP_WRITE) begin
                    n_cnt[C_WMISS] = sat_add(r_cnt[C_WMISS], CNT_W'(1));
                end else begin
                    n_cnt[C_RMISS] = sat_add(r_cnt[C_RMISS], CNT_W'(1));
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mode   <= MODE_RESET;
            r_tok0   <= '0;
            r_ptr    <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NCNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            // token enters cell 0 for a single cycle
            r_tok0.act   <= in_acc;
            r_tok0.found <= 1'b0;
            r_tok0.wb    <= 1'b0;
            if (bc.wr_en) begin
                r_ptr <= ptr_next;
            end
            for (int k = 0; k < NCNT; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
            if (r_state == ST_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // access context and result payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_s_axis_tuser;
            r_addr  <= i_s_axis_tdata[AW-1:0];
            r_mask  <= {AW{1'b1}} << shift_c;
            r_count <= count_c;
            r_vic   <= vic_c;
            r_bsize <= BSZ_W'(1) << shift_c;
        end
        if (tok_back) begin
            r_hit <= !miss;
            r_wb  <= miss && tok[TOTAL_WORDS].wb;
        end
        if (r_state == ST_FIN && out_free) begin
            r_ohit <= r_hit;
            r_owb  <= r_wb;
            for (int k = 0; k < NCNT; k++) begin
                r_ocnt[k] <= r_cnt[k];
            end
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = {r_owb, r_ohit};
    assign o_m_axis_tdata  = {r_ocnt[C_WMISS], r_ocnt[C_WHIT], r_ocnt[C_RMISS],
                              r_ocnt[C_RHIT], r_ocnt[C_WWR], r_ocnt[C_WRD]};

endmodule

// File: design/facw_cell.sv
// One cache entry cell: stored address, valid and dirty, local tag compare.
// Depends on facw_pkg (t_token, t_bcast).
module facw_cell #(
    parameter int TOTAL_WORDS = facw_pkg::DEF_TOTAL_WORDS,
    parameter int ADDR_W      = facw_pkg::DEF_ADDR_BITS,
    parameter int IDX         = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  facw_pkg::t_token                   i_tok,
    output facw_pkg::t_token                   o_tok,
    input  facw_pkg::t_bcast                   i_bc,
    input  logic [$clog2(TOTAL_WORDS)-1:0]     i_vic,
    input  logic [ADDR_W-1:0]                  i_addr,
    input  logic [ADDR_W-1:0]                  i_mask,
    input  logic [$clog2(TOTAL_WORDS+1)-1:0]   i_count
);
    import facw_pkg::*;

    localparam int IW = $clog2(TOTAL_WORDS);
    localparam int CW = $clog2(TOTAL_WORDS + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [CW-1:0] MY_POS = CW'(IDX);

    logic [ADDR_W-1:0] r_addr;
    logic              r_valid;
    logic              r_dirty;
    t_token            r_tok;
    t_token            n_tok;

    logic match;
    logic take;
    logic is_vic;

    always_comb begin
        match  = r_valid && (MY_POS < i_count) && (((r_addr ^ i_addr) & i_mask) == '0);
        take   = i_tok.act && !i_tok.found && match;
        is_vic = (i_vic == MY_IDX);
        n_tok.act   = i_tok.act;
        n_tok.found = i_tok.found || take;
        n_tok.wb    = i_tok.wb || (i_tok.act && is_vic && r_valid && r_dirty);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_bc.wr_en && is_vic) begin
                r_valid <= 1'b1;
                r_dirty <= i_bc.wr_dirty;
            end else if (take && i_bc.is_write) begin
                r_dirty <= 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_bc.wr_en && is_vic) begin
            r_addr <= i_addr;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for fully_assoc_cache_fifo_writeback: drives read/write accesses,
// predicts hit/writeback flags and the six event counters, checks each result transaction.
// Depends on facw_pkg and the cache RTL.
module testbench;
    import facw_pkg::*;

    localparam int ENTRIES      = DEF_TOTAL_WORDS;
    localparam int NUM_COUNTERS = 6;
    localparam int TAIL_WAIT    = DEF_TOTAL_WORDS + 40;  // one full lookup plus margin
    localparam int LONG_HOLD    = 900;                   // receiver hold-off, in cycles
    localparam int STALL_LIMIT  = 5000;                  // cycles with no transaction at all

    // Slot order of the running counters in the result data word.
    typedef enum int {
        CTR_WORDS_READ,
        CTR_WORDS_WRITTEN,
        CTR_READ_HITS,
        CTR_READ_MISSES,
        CTR_WRITE_HITS,
        CTR_WRITE_MISSES
    } t_counter;

    typedef struct packed {
        logic                            hit;
        logic                            wb;
        logic [NUM_COUNTERS-1:0][31:0]   cnt;
    } t_result;

    string ctr_label [NUM_COUNTERS] = '{"words_read", "words_written", "read_hits",
                                        "read_misses", "write_hits", "write_misses"};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [MODE_W-1:0]   i_cfg_data;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [31:0]         i_s_axis_tdata;
    logic                i_s_axis_tuser;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [191:0]        o_m_axis_tdata;
    logic [1:0]          o_m_axis_tuser;

    // Shadow of the cache state.
    logic [MODE_W-1:0]   mode_reg;
    logic [31:0]         line_addr [ENTRIES];
    logic                line_valid [ENTRIES];
    logic                line_dirty [ENTRIES];
    int unsigned         fifo_ptr;
    logic [NUM_COUNTERS-1:0][31:0] counters;

    t_result             pending_results [$];
    int unsigned         err_count = 0;
    int unsigned         quiet_cycles = 0;
    bit                  idle_en = 1'b1;
    int unsigned         hold_req = 0;

    fully_assoc_cache_fifo_writeback #(
        .TOTAL_WORDS (ENTRIES),
        .ADDR_BITS   (DEF_ADDR_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mode 0 behaves as 1, anything above 8 as 8.
    function automatic int unsigned tag_shift(logic [MODE_W-1:0] m);
        if (m < MODE_MIN) return int'(MODE_MIN) - 1;
        if (m > MODE_MAX) return int'(MODE_MAX) - 1;
        return int'(m) - 1;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] c, int unsigned v);
        logic [32:0] s;
        s = {1'b0, c} + 33'(v);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Predict one access and update the shadow state.
    function automatic t_result cache_lookup(logic op, logic [31:0] addr);
        int unsigned shift;
        int unsigned bsize;
        int unsigned count;
        int unsigned where;
        int unsigned victim;
        logic        hit;
        t_result     r;
        shift = tag_shift(mode_reg);
        bsize = 1 << shift;
        count = ENTRIES >> shift;
        if (count < 1) count = 1;
        hit   = 1'b0;
        where = 0;
        for (int i = 0; i < count; i++) begin
            if (!hit && line_valid[i] && ((line_addr[i] >> shift) == (addr >> shift))) begin
                hit   = 1'b1;
                where = i;
            end
        end
        r.wb = 1'b0;
        if (hit) begin
            if (op == OP_WRITE) begin
                line_dirty[where] = 1'b1;
                counters[CTR_WRITE_HITS] = sat_add(counters[CTR_WRITE_HITS], 1);
            end else begin
                counters[CTR_READ_HITS] = sat_add(counters[CTR_READ_HITS], 1);
            end
        end else begin
            // a pointer left past the entry count by a mode change restarts at entry 0
            victim   = (fifo_ptr >= count) ? 0 : fifo_ptr;
            fifo_ptr = (victim + 1 >= count) ? 0 : victim + 1;
            if (line_valid[victim] && line_dirty[victim]) begin
                r.wb = 1'b1;
                counters[CTR_WORDS_WRITTEN] = sat_add(counters[CTR_WORDS_WRITTEN], bsize);
            end
            counters[CTR_WORDS_READ] = sat_add(counters[CTR_WORDS_READ], bsize);
            line_addr[victim]  = addr;
            line_valid[victim] = 1'b1;
            line_dirty[victim] = (op == OP_WRITE);
            if (op == OP_WRITE)
                counters[CTR_WRITE_MISSES] = sat_add(counters[CTR_WRITE_MISSES], 1);
            else
                counters[CTR_READ_MISSES] = sat_add(counters[CTR_READ_MISSES], 1);
        end
        r.hit = hit;
        r.cnt = counters;
        return r;
    endfunction

    // Mostly addresses near a base tag so lines get reused and evicted; some fully random.
    function automatic logic [31:0] pick_address(logic [31:0] base_tag);
        int unsigned shift;
        int unsigned span;
        logic [31:0] low_mask;
        shift    = tag_shift(mode_reg);
        low_mask = (32'd1 << shift) - 32'd1;
        if ($urandom_range(0, 4) == 0) return $urandom;
        if ($urandom_range(0, 1) == 0)
            span = 8;
        else
            span = (ENTRIES >> shift) + (ENTRIES >> (shift + 1)) + 1;
        return ((base_tag + $urandom_range(0, span)) << shift) | ($urandom & low_mask);
    endfunction

    function automatic void check_field(string label, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, label, exp_v, act_v);
            err_count++;
        end
    endfunction

    // Called at a rising edge; returns at the edge the access transaction completes.
    task automatic send_access(logic op, logic [31:0] addr);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= addr;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(cache_lookup(op, addr));
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Only called with the cache idle.
    task automatic set_mode(logic [MODE_W-1:0] m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        mode_reg = m;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random_phase(logic [MODE_W-1:0] m, int n);
        logic [31:0] base;
        wait_drained();
        set_mode(m);
        base = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
        repeat (n) send_access(1'($urandom_range(0, 1)), pick_address(base));
    endtask

    // One-word blocks: cold misses, hits, write hit marking dirty, address extremes.
    task automatic test_directed_basic();
        set_mode(MODE_MIN);
        send_access(OP_READ,  32'h0000_0000);
        send_access(OP_READ,  32'h0000_0000);
        send_access(OP_WRITE, 32'h0000_0000);
        send_access(OP_WRITE, 32'hFFFF_FFFF);
        send_access(OP_READ,  32'hFFFF_FFFF);
        send_access(OP_READ,  32'h8000_0000);
        send_access(OP_WRITE, 32'h7FFF_FFFF);
        send_access(OP_READ,  32'h5555_5555);
        send_access(OP_WRITE, 32'hAAAA_AAAA);
        send_access(OP_READ,  32'h0000_0001);
    endtask

    // Largest blocks leave two entries: pointer beyond the count, old lines compared with
    // the new shift, and dirty victims written back.
    task automatic test_eviction_large_blocks();
        wait_drained();
        set_mode(MODE_MAX);
        send_access(OP_READ,  32'h0000_007F);
        send_access(OP_WRITE, 32'h0000_1000);
        send_access(OP_WRITE, 32'h0000_2000);
        send_access(OP_READ,  32'h0000_3000);
        send_access(OP_READ,  32'h0000_2080);
        send_access(OP_WRITE, 32'h0000_307F);
        send_access(OP_READ,  32'h0000_4000);
    endtask

    // Mode values outside 1..8 clamp to the nearest legal mode.
    task automatic test_mode_out_of_range();
        wait_drained();
        set_mode(MODE_W'(0));
        send_access(OP_WRITE, 32'h0000_0010);
        send_access(OP_READ,  32'h0000_0011);
        send_access(OP_READ,  32'h0000_0010);
        wait_drained();
        set_mode(MODE_W'(15));
        send_access(OP_WRITE, 32'hFFFF_FF00);
        send_access(OP_READ,  32'hFFFF_FF7F);
        send_access(OP_WRITE, 32'h0000_0000);
    endtask

    task automatic test_random_modes();
        logic [MODE_W-1:0] mode_seq [10];
        mode_seq = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd6, 4'd2, 4'd7, 4'd4, 4'd5};
        foreach (mode_seq[i]) run_random_phase(mode_seq[i], 45);
    endtask

    // Receiver holds off long enough for the input side to back up.
    task automatic test_backpressure();
        logic [31:0] base;
        wait_drained();
        base = $urandom;
        hold_req = LONG_HOLD;
        repeat (10) send_access(1'($urandom_range(0, 1)), pick_address(base));
        wait_drained();
    endtask

    task automatic test_final_no_idle();
        wait_drained();
        idle_en = 1'b0;
        run_random_phase(MODE_W'(2), 70);
    endtask

    // Result side ready: random bursts, plus the long hold on request.
    initial begin
        int unsigned n;
        forever begin
            if (hold_req != 0) begin
                n = hold_req;
                hold_req = 0;
                i_m_axis_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 16);
                i_m_axis_tready <= 1'b0;
            end else begin
                n = $urandom_range(1, 16);
                i_m_axis_tready <= 1'b1;
            end
            repeat (n) @(posedge i_clk);
        end
    end

    // Result checker: every result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result transaction with no access pending", $time);
                err_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("hit", 32'(exp_r.hit), 32'(o_m_axis_tuser[0]));
                check_field("writeback", 32'(exp_r.wb), 32'(o_m_axis_tuser[1]));
                for (int k = 0; k < NUM_COUNTERS; k++)
                    check_field(ctr_label[k], exp_r.cnt[k], o_m_axis_tdata[k*32 +: 32]);
            end
        end
    end

    // Watchdog on cycles where no channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= MODE_RESET;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_READ;
        mode_reg = MODE_RESET;
        fifo_ptr = 0;
        counters = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            line_addr[i]  = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basic();
        test_eviction_large_blocks();
        test_mode_out_of_range();
        test_random_modes();
        test_backpressure();
        test_final_no_idle();

        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
